// ===== rtl/loser_tree_kway_merge_top_k_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the loser tree merge block.
// The checking forms are compiled in simulation and vanish in synthesis.
// ---------------------------------------------------------------------------
`ifndef LOSER_TREE_KWAY_MERGE_TOP_K_TOP_DEFINES_SVH
`define LOSER_TREE_KWAY_MERGE_TOP_K_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent holds in the same cycle as the antecedent.
`define LTKM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Consequent holds in the cycle after the antecedent.
`define LTKM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LTKM_ASSERT_SAME(label, ante, cons)
`define LTKM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/ltkm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltkm_pkg
// Shared types, constants and the comparison rule of the loser tree merge.
// ---------------------------------------------------------------------------
package ltkm_pkg;

	localparam int VAL_W = 32;
	localparam int OUT_CAP = 32;
	localparam logic [VAL_W-1:0] END_VALUE = 32'h8000_0000;

	// Input operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_START = 1'b1;

	// Configuration register indexes.
	localparam logic REG_LIST_COUNT = 1'b0;
	localparam logic REG_OUTPUT_LIMIT = 1'b1;

	// One competitor: whether its list still has data, and its head value.
	typedef struct packed {
		logic                    live;
		logic signed [VAL_W-1:0] val;
	} cand_t;

	// True when a strictly beats b; an exhausted list always loses.
	function automatic logic beats(input cand_t a, input cand_t b);
		return a.live && (!b.live || (a.val > b.val));
	endfunction

endpackage

// ===== rtl/ltkm_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltkm_store
// List storage: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ltkm_store import ltkm_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic                    clk,
	input  cand_t                   wr,
	input  logic [AW-1:0]           wr_addr,
	input  logic [AW-1:0]           rd_addr,
	output logic signed [VAL_W-1:0] rd_data
);

	logic signed [VAL_W-1:0] mem_q [DEPTH];

	// The live bit of the write struct serves as write enable.
	always_ff @(posedge clk) begin
		if (wr.live) begin
			mem_q[wr_addr] <= wr.val;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/loser_tree_kway_merge_top_k_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// loser_tree_kway_merge_top_k_top
// Loads descending lists and merges them largest first through a loser tree
// that one comparator walks, closing each run with an end transaction.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  in       | in        | in_valid / in_ready       | op, list_id, value
//  out      | out       | out_valid / out_ready     | merged_value, is_end
//  cfg      | in        | cfg_write (no wait)       | cfg_index, cfg_data
//
// A load is taken while idle. A start with one list copies list 0; else it sums
// the first list_count fill counts, builds the tree by reading and comparing the
// children of each inner node, then per merged value emits, refetches the winner
// and replays up from its leaf; one read port and one comparator set these steps.
// Reset clears the control state, fill counts and read positions.
// A stalled out channel holds the sequencer until the output register frees.
// ---------------------------------------------------------------------------
`include "loser_tree_kway_merge_top_k_top_defines.svh"

module loser_tree_kway_merge_top_k_top import ltkm_pkg::*; #(
	parameter int MAX_LISTS = 8,
	parameter int LIST_DEPTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    op,
	input  logic [2:0]              list_id,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] merged_value,
	output logic                    is_end,
	input  logic                    cfg_write,
	input  logic                    cfg_index,
	input  logic [5:0]              cfg_data
);

	localparam int LW = $clog2(MAX_LISTS);
	localparam int NW = $clog2(2 * MAX_LISTS);
	localparam int KW = $clog2(MAX_LISTS + 1);
	localparam int SD = MAX_LISTS * LIST_DEPTH;
	localparam int AW = $clog2(SD);
	localparam int RW = $clog2(SD + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_COPY_RD, ST_COPY_EM, ST_SUM, ST_BLD_L, ST_BLD_LW, ST_BLD_R,
		ST_BLD_CMP, ST_EMIT, ST_RPL_F, ST_RPL_W, ST_RPL_C, ST_RPL_CMP, ST_END
	} state_t;

	state_t          st_q;
	logic [3:0]      list_count_q;
	logic [5:0]      output_limit_q;
	logic [5:0]      fill_q [MAX_LISTS];
	logic [5:0]      rp_q [MAX_LISTS];
	logic [LW-1:0]   loser_q [2*MAX_LISTS];
	logic [LW-1:0]   winner_q [2*MAX_LISTS];
	logic [KW-1:0]   k_q;
	logic [5:0]      limit_q;
	logic [5:0]      emit_q;
	logic [5:0]      j_q;
	logic [RW-1:0]   rem_q;
	logic [NW-1:0]   i_q;
	logic [LW-1:0]   l_id_q;
	logic [LW-1:0]   r_id_q;
	logic [LW-1:0]   w_id_q;
	cand_t           l_c_q;
	cand_t           w_c_q;
	logic            live_q;
	logic            out_valid_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic            out_end_q;

	logic            slot_free;
	logic            out_load;
	logic [LW-1:0]   fid;
	logic [LW-1:0]   lid;
	logic            id_ok;
	cand_t           wr;
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   rd_addr;
	logic signed [VAL_W-1:0] rd_data;
	cand_t           rd_c;
	cand_t           cmp_a;
	cand_t           cmp_b;
	logic            cmp_win;
	logic [KW-1:0]   k_sat;
	logic [5:0]      lim_sat;
	logic [RW-1:0]   rem_sum;
	logic [NW-1:0]   child;

	assign in_ready     = (st_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign merged_value = out_val_q;
	assign is_end       = out_end_q;
	assign slot_free    = !out_valid_q || out_ready;
	assign out_load     = slot_free && (st_q inside {ST_COPY_EM, ST_EMIT, ST_END});
	assign rd_c         = '{live: live_q, val: rd_data};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_count_q   <= 4'd2;
			output_limit_q <= 6'd10;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LIST_COUNT:   list_count_q <= cfg_data[3:0];
				REG_OUTPUT_LIMIT: output_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturated list count and output limit for a new run.
	always_comb begin
		if (list_count_q == 4'd0) begin
			k_sat = KW'(1);
		end else if (32'(list_count_q) > MAX_LISTS) begin
			k_sat = KW'(MAX_LISTS);
		end else begin
			k_sat = KW'(list_count_q);
		end
		if (output_limit_q == 6'd0) begin
			lim_sat = 6'd1;
		end else if (32'(output_limit_q) > OUT_CAP) begin
			lim_sat = 6'(OUT_CAP);
		end else begin
			lim_sat = output_limit_q;
		end
	end

	// Load write port.
	assign lid     = LW'(list_id);
	assign id_ok   = 32'(list_id) < MAX_LISTS;
	assign wr.live = (st_q == ST_IDLE) && in_valid && (op == OP_LOAD) && id_ok
		&& (32'(fill_q[lid]) < LIST_DEPTH);
	assign wr.val  = value;
	assign wr_addr = AW'(32'(lid) * LIST_DEPTH + 32'(fill_q[lid]));

	// Child selection while building: leaves map straight to list ids.
	always_comb begin
		if (st_q == ST_BLD_R) begin
			child = {i_q[NW-2:0], 1'b1};
		end else begin
			child = {i_q[NW-2:0], 1'b0};
		end
	end

	// List whose head is fetched this cycle.
	always_comb begin
		case (st_q)
			ST_BLD_L, ST_BLD_R: begin
				if (32'(child) >= 32'(k_q)) begin
					fid = LW'(32'(child) - 32'(k_q));
				end else begin
					fid = winner_q[child];
				end
			end
			ST_RPL_F: fid = w_id_q;
			ST_RPL_C: fid = loser_q[i_q];
			default:  fid = '0;
		endcase
	end

	// Read address: straight through list 0 when copying, else a list head.
	// The copy address is held while the output waits so the data stays put.
	always_comb begin
		if ((st_q == ST_COPY_RD) || (st_q == ST_COPY_EM)) begin
			rd_addr = AW'(j_q);
		end else begin
			rd_addr = AW'(32'(fid) * LIST_DEPTH + 32'(rp_q[fid]));
		end
	end

	// The one comparator, shared by the build and the replay.
	always_comb begin
		if (st_q == ST_BLD_CMP) begin
			cmp_a = l_c_q;
			cmp_b = rd_c;
		end else begin
			cmp_a = rd_c;
			cmp_b = w_c_q;
		end
		cmp_win = beats(cmp_a, cmp_b);
	end

	assign rem_sum = rem_q + RW'(fill_q[LW'(i_q)]);

	ltkm_store #(
		.DEPTH(SD),
		.AW(AW)
	) u_store (
		.clk(clk),
		.wr(wr),
		.wr_addr(wr_addr),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
			emit_q      <= '0;
			rem_q       <= '0;
			for (int n = 0; n < MAX_LISTS; n++) begin
				fill_q[n] <= '0;
				rp_q[n]   <= '0;
			end
		end else begin
			live_q <= rp_q[fid] < fill_q[fid];
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (op == OP_LOAD) begin
							if (wr.live) begin
								fill_q[lid] <= fill_q[lid] + 6'd1;
							end
						end else begin
							k_q     <= k_sat;
							limit_q <= lim_sat;
							emit_q  <= '0;
							rem_q   <= '0;
							i_q     <= '0;
							j_q     <= '0;
							for (int n = 0; n < MAX_LISTS; n++) begin
								rp_q[n] <= '0;
							end
							st_q <= (k_sat == KW'(1)) ? ST_COPY_RD : ST_SUM;
						end
					end
				end
				ST_COPY_RD: begin
					st_q <= (j_q < fill_q[0]) ? ST_COPY_EM : ST_END;
				end
				ST_COPY_EM: begin
					if (slot_free) begin
						out_val_q   <= rd_data;
						out_end_q   <= 1'b0;
						j_q         <= j_q + 6'd1;
						st_q        <= ST_COPY_RD;
					end
				end
				ST_SUM: begin
					rem_q <= rem_sum;
					if (32'(i_q) == 32'(k_q) - 1) begin
						i_q  <= NW'(32'(k_q) - 1);
						st_q <= (rem_sum == '0) ? ST_END : ST_BLD_L;
					end else begin
						i_q <= i_q + NW'(1);
					end
				end
				ST_BLD_L: begin
					l_id_q <= fid;
					st_q   <= ST_BLD_LW;
				end
				ST_BLD_LW: begin
					l_c_q <= rd_c;
					st_q  <= ST_BLD_R;
				end
				ST_BLD_R: begin
					r_id_q <= fid;
					st_q   <= ST_BLD_CMP;
				end
				ST_BLD_CMP: begin
					// Left wins only when strictly greater.
					if (cmp_win) begin
						winner_q[i_q] <= l_id_q;
						loser_q[i_q]  <= r_id_q;
						w_id_q        <= l_id_q;
						w_c_q         <= l_c_q;
					end else begin
						winner_q[i_q] <= r_id_q;
						loser_q[i_q]  <= l_id_q;
						w_id_q        <= r_id_q;
						w_c_q         <= rd_c;
					end
					if (i_q == NW'(1)) begin
						st_q <= ST_EMIT;
					end else begin
						i_q  <= i_q - NW'(1);
						st_q <= ST_BLD_L;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_val_q      <= w_c_q.live ? w_c_q.val : '0;
						out_end_q      <= 1'b0;
						rp_q[w_id_q]   <= rp_q[w_id_q] + 6'd1;
						rem_q          <= rem_q - RW'(1);
						emit_q         <= emit_q + 6'd1;
						i_q <= NW'((32'(k_q) + 32'(w_id_q)) >> 1);
						if ((rem_q != RW'(1)) && ((emit_q + 6'd1) < limit_q)) begin
							st_q <= ST_RPL_F;
						end else begin
							st_q <= ST_END;
						end
					end
				end
				ST_RPL_F: begin
					st_q <= ST_RPL_W;
				end
				ST_RPL_W: begin
					w_c_q <= rd_c;
					st_q  <= ST_RPL_C;
				end
				ST_RPL_C: begin
					l_id_q <= fid;
					st_q   <= ST_RPL_CMP;
				end
				ST_RPL_CMP: begin
					// The stored loser takes over only when strictly greater.
					if (cmp_win) begin
						loser_q[i_q] <= w_id_q;
						w_id_q       <= l_id_q;
						w_c_q        <= rd_c;
					end
					i_q  <= i_q >> 1;
					st_q <= (i_q == NW'(1)) ? ST_EMIT : ST_RPL_C;
				end
				ST_END: begin
					if (slot_free) begin
						out_val_q   <= END_VALUE;
						out_end_q   <= 1'b1;
						for (int n = 0; n < MAX_LISTS; n++) begin
							fill_q[n] <= '0;
						end
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// The end transaction always carries the sentinel value.
	`LTKM_ASSERT_SAME(a_end_value, out_valid && is_end, merged_value == END_VALUE)
	// A start transaction makes the block busy on the next cycle.
	`LTKM_ASSERT_NEXT(a_start_busy, in_valid && in_ready && (op == OP_START), !in_ready)
	// A merge of several lists never emits past its limit.
	`LTKM_ASSERT_SAME(a_limit, (st_q != ST_IDLE) && (k_q != KW'(1)), emit_q <= limit_q)

endmodule

// ===== verif/loser_tree_kway_merge_top_k_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// loser_tree_kway_merge_top_k_top_test
// Self-checking bench for the loser tree merge block. Lists are loaded,
// merged and the merged stream is compared value by value with a shadow
// loser tree kept in the bench, under random idling on both channels.
// ---------------------------------------------------------------------------
module loser_tree_kway_merge_top_k_top_test;
	import ltkm_pkg::*;

	localparam int NLISTS = 8;
	localparam int DEPTH = 32;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic              op;
		logic [2:0]        id;
		logic signed [31:0] val;
	} load_item_t;

	typedef struct {
		logic signed [31:0] val;
		logic               last;
	} merged_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = OP_LOAD;
	logic [2:0] list_id = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] merged_value;
	logic is_end;
	logic cfg_write = 1'b0;
	logic cfg_index = REG_LIST_COUNT;
	logic [5:0] cfg_data = '0;

	loser_tree_kway_merge_top_k_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .list_id(list_id), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.merged_value(merged_value), .is_end(is_end),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow state of the merge engine.
	logic signed [31:0] sh_store [NLISTS][DEPTH];
	int sh_fill [NLISTS];
	int sh_pos [NLISTS];
	int sh_loser [2*NLISTS];
	int sh_winner [2*NLISTS];
	int sh_remaining;
	int sh_emitted;
	logic [3:0] sh_list_count = 4'd2;
	logic [5:0] sh_out_limit = 6'd10;

	load_item_t pend_q [$];
	merged_item_t merged_q [$];
	load_item_t cur_item;
	int mismatches = 0;
	int cycles = 0;
	int items_pushed = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic bit list_live(int l);
		return l < NLISTS && sh_pos[l] < sh_fill[l];
	endfunction

	// True when list a strictly beats list b; exhausted lists always lose.
	function automatic bit list_beats(int a, int b);
		if (!list_live(a))
			return 0;
		if (!list_live(b))
			return 1;
		return sh_store[a][sh_pos[a]] > sh_store[b][sh_pos[b]];
	endfunction

	function automatic void emit(logic signed [31:0] v, logic last);
		merged_item_t m;
		m.val = v;
		m.last = last;
		merged_q.push_back(m);
	endfunction

	function automatic void take_head(int w);
		emit(sh_store[w][sh_pos[w]], 1'b0);
		sh_pos[w]++;
		sh_remaining--;
		sh_emitted++;
	endfunction

	// Work out the results of one accepted transaction.
	function automatic void predict_merge(load_item_t it);
		int k, lim, w, t, node;
		if (it.op == OP_LOAD) begin
			if (sh_fill[it.id] < DEPTH) begin
				sh_store[it.id][sh_fill[it.id]] = it.val;
				sh_fill[it.id]++;
			end
			return;
		end
		k = (sh_list_count == 0) ? 1 : (sh_list_count > NLISTS ? NLISTS : sh_list_count);
		lim = (sh_out_limit == 0) ? 1 : (sh_out_limit > OUT_CAP ? OUT_CAP : sh_out_limit);
		sh_emitted = 0;
		if (k == 1) begin
			for (int j = 0; j < sh_fill[0]; j++)
				emit(sh_store[0][j], 1'b0);
			sh_pos[0] = sh_fill[0];
			sh_remaining = 0;
		end else begin
			sh_remaining = 0;
			for (int i = 0; i < k; i++) begin
				sh_remaining += sh_fill[i];
				sh_pos[i] = 0;
			end
			if (sh_remaining > 0) begin
				for (int i = k; i < 2*k; i++) begin
					sh_loser[i] = i - k;
					sh_winner[i] = i - k;
				end
				// Initial build: the left side wins only when strictly greater.
				for (int i = k - 1; i > 0; i--) begin
					if (list_beats(sh_winner[2*i], sh_winner[2*i+1])) begin
						sh_winner[i] = sh_winner[2*i];
						sh_loser[i] = sh_winner[2*i+1];
					end else begin
						sh_winner[i] = sh_winner[2*i+1];
						sh_loser[i] = sh_winner[2*i];
					end
				end
				sh_loser[0] = sh_winner[1];
				take_head(sh_loser[0]);
				// Replay: the challenger keeps winning on ties.
				while (sh_remaining > 0 && sh_emitted < lim) begin
					w = sh_loser[0];
					for (node = (k + w) >> 1; node > 0; node >>= 1) begin
						if (list_beats(sh_loser[node], w)) begin
							t = w;
							w = sh_loser[node];
							sh_loser[node] = t;
						end
					end
					sh_loser[0] = w;
					take_head(w);
				end
			end
		end
		emit(END_VALUE, 1'b1);
		for (int i = 0; i < NLISTS; i++)
			sh_fill[i] = 0;
	endfunction

	// Driver: bursts of transactions separated by random gaps.
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_merge(cur_item);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					cur_item = pend_q.pop_front();
					op <= cur_item.op;
					list_id <= cur_item.id;
					value <= cur_item.val;
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each merged transaction and stall on its own pattern.
	int ready_mode = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (merged_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result value=%0d end=%0b", merged_value, is_end);
				end else begin
					merged_item_t m;
					m = merged_q.pop_front();
					if (m.val !== merged_value || m.last !== is_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected value=%0d end=%0b, got value=%0d end=%0b",
								m.val, m.last, merged_value, is_end);
					end
				end
			end
			if (cycles % 256 == 0)
				ready_mode = $urandom_range(0, 2);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (ready_mode == 1) begin
				out_ready <= ($urandom_range(0, 2) != 0);
			end else if (ready_mode == 2 && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push_item(logic o, logic [2:0] id, logic signed [31:0] v);
		load_item_t it;
		it.op = o;
		it.id = id;
		it.val = v;
		pend_q.push_back(it);
		items_pushed++;
	endtask

	// Wait until the block has delivered everything and gone quiet.
	// Sampling at the falling edge sees the settled state of the last edge.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pend_q.size() > 0 || in_valid || merged_q.size() > 0 || !in_ready);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [5:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_LIST_COUNT)
			sh_list_count = data[3:0];
		else
			sh_out_limit = data;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_config(logic [5:0] cnt, logic [5:0] lim);
		wait_quiet();
		write_reg(REG_LIST_COUNT, cnt);
		write_reg(REG_OUTPUT_LIMIT, lim);
	endtask

	// One random merge: descending lists, mostly, loaded interleaved.
	task automatic random_merge();
		int len [NLISTS];
		int sorted, k, pick, left;
		int vals [NLISTS][$];
		k = (sh_list_count == 0) ? 1 : (sh_list_count > NLISTS ? NLISTS : sh_list_count);
		sorted = ($urandom_range(0, 7) != 0);
		left = 0;
		for (int l = 0; l < NLISTS; l++) begin
			if (l < k)
				len[l] = $urandom_range(0, 5);
			else
				len[l] = ($urandom_range(0, 3) == 0) ? 1 : 0;
			if ($urandom_range(0, 15) == 0)
				len[l] = $urandom_range(33, 35);
			vals[l].delete();
			for (int j = 0; j < len[l]; j++)
				vals[l].push_back($urandom_range(0, 1) ? int'($urandom)
					: int'($urandom_range(0, 6)) - 3);
			if (sorted)
				vals[l].rsort();
			left += len[l];
		end
		while (left > 0) begin
			pick = $urandom_range(0, NLISTS - 1);
			if (vals[pick].size() > 0) begin
				push_item(OP_LOAD, pick[2:0], vals[pick].pop_front());
				left--;
			end
		end
		push_item(OP_START, 3'($urandom), $urandom);
	endtask

	initial begin
		for (int l = 0; l < NLISTS; l++) begin
			sh_fill[l] = 0;
			sh_pos[l] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a merge with no data at the reset settings.
		push_item(OP_START, 3'd0, 32'sd0);
		// Single list copied whole, with the value extremes.
		set_config(6'd1, 6'd0);
		push_item(OP_LOAD, 3'd0, 32'sh7fff_ffff);
		push_item(OP_LOAD, 3'd0, 32'sd0);
		push_item(OP_LOAD, 3'd0, 32'sh8000_0000);
		push_item(OP_LOAD, 3'd3, 32'sd5);
		push_item(OP_START, 3'd7, 32'shffff_ffff);
		// Three lists with ties at the head, above the output cap.
		set_config(6'd3, 6'd63);
		push_item(OP_LOAD, 3'd0, 32'sd10);
		push_item(OP_LOAD, 3'd1, 32'sd10);
		push_item(OP_LOAD, 3'd2, 32'sd10);
		push_item(OP_LOAD, 3'd0, 32'sd10);
		push_item(OP_LOAD, 3'd1, 32'sd7);
		push_item(OP_LOAD, 3'd0, 32'sd5);
		push_item(OP_START, 3'd0, 32'sd0);
		// List count saturated, one value per list, limit of one.
		set_config(6'd15, 6'd1);
		for (int l = 0; l < NLISTS; l++)
			push_item(OP_LOAD, l[2:0], 32'sd100 - l);
		push_item(OP_START, 3'd0, 32'sd0);
		// Zero list count acts as one list; empty merge.
		set_config(6'd0, 6'd32);
		push_item(OP_START, 3'd0, 32'sd0);

		// Random merges, reconfigured now and then.
		while (items_pushed < 240) begin
			if ($urandom_range(0, 2) == 0)
				set_config(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
					: $urandom_range(1, 8), $urandom_range(0, 63));
			random_merge();
		end

		wait_quiet();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ltkm_pkg.sv
rtl/ltkm_store.sv
rtl/loser_tree_kway_merge_top_k_top.sv
verif/loser_tree_kway_merge_top_k_top_test.sv
